/* sv/emb_pkg.sv */
`timescale 1ns / 1ps

package emb_pkg;

  localparam int SPEED_BITS = 8;
  localparam int TIMER_BITS = 16;
  localparam int DRIVE_BITS = SPEED_BITS + 1;
  localparam int CFG_BITS   = 16;
  localparam int IDX_BITS   = 3;
  localparam int WIDE_BITS  = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

  localparam logic [IDX_BITS-1:0] REG_BACKOFF_ENABLE = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] REG_HALT_TIME      = IDX_BITS'(1);
  localparam logic [IDX_BITS-1:0] REG_REVERSE_TIME   = IDX_BITS'(2);
  localparam logic [IDX_BITS-1:0] REG_FORWARD_TIME   = IDX_BITS'(3);
  localparam logic [IDX_BITS-1:0] REG_TRIGGER_TIME   = IDX_BITS'(4);

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_SPEED = 2'd1,
    OP_SET_DIR   = 2'd2,
    OP_SET_ON    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_INACTIVE = 3'd0,
    PH_HALT1    = 3'd1,
    PH_REVERSE  = 3'd2,
    PH_HALT2    = 3'd3,
    PH_FORWARD  = 3'd4
  } phase_t;

  typedef struct packed {
    op_t                   operation;
    logic [SPEED_BITS-1:0] speed_value;
    logic                  dir_value;
    logic                  on_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DRIVE_BITS-1:0] drive_speed;
    phase_t                       phase;
  } out_item_t;

  typedef struct packed {
    logic                backoff_enable;
    logic [CFG_BITS-1:0] halt_time;
    logic [CFG_BITS-1:0] reverse_time;
    logic [CFG_BITS-1:0] forward_time;
    logic [CFG_BITS-1:0] trigger_time;
  } cfg_t;

  localparam logic [WIDE_BITS-1:0] TIMER_MAX_WIDE = WIDE_BITS'({TIMER_BITS{1'b1}});

  function automatic logic [TIMER_BITS-1:0] load_time(input logic [CFG_BITS-1:0] ms);
    logic [WIDE_BITS-1:0] m;
    m = WIDE_BITS'(ms);
    if (m > TIMER_MAX_WIDE) begin
      return {TIMER_BITS{1'b1}};
    end
    return TIMER_BITS'(m);
  endfunction

endpackage

/* sv/extruder_motor_backoff_sequencer_top.sv */
`timescale 1ns / 1ps
// a beat accepted on item passes through the stage register and then the result register
// throughput: one beat per cycle while result_ready keeps up, set by the state update in emb_core
// the input register takes a new beat while a result waits, as long as it can move on
// reset is synchronous and active high: registers go to their defaults,
// phase inactive, timers stopped, speed zero, direction forward, motor off

module extruder_motor_backoff_sequencer_top
  import emb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  in_item_t            item,
  output logic                result_valid,
  input  logic                result_ready,
  output out_item_t           result,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  cfg_t      cfg;
  in_item_t  stage;
  logic      stage_valid;
  logic      fire;
  out_item_t result_next;

  assign fire       = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || fire;

  emb_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  emb_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (stage),
    .fire       (fire),
    .result_next(result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else if (item_ready && item_valid) begin
      stage <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input not ready while output is empty");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !result_valid |=> result_valid)
    else $error("staged beat did not reach the output");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid && !stage_valid)
    else $error("valid flags not cleared by reset");

endmodule

/* sv/emb_cfg.sv */
`timescale 1ns / 1ps

module emb_cfg
  import emb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.backoff_enable <= 1'b1;
      cfg.halt_time      <= CFG_BITS'(5);
      cfg.reverse_time   <= CFG_BITS'(500);
      cfg.forward_time   <= CFG_BITS'(300);
      cfg.trigger_time   <= CFG_BITS'(300);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BACKOFF_ENABLE: cfg.backoff_enable <= cfg_data[0];
        REG_HALT_TIME:      cfg.halt_time      <= cfg_data;
        REG_REVERSE_TIME:   cfg.reverse_time   <= cfg_data;
        REG_FORWARD_TIME:   cfg.forward_time   <= cfg_data;
        REG_TRIGGER_TIME:   cfg.trigger_time   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* sv/emb_core.sv */
`timescale 1ns / 1ps

module emb_core
  import emb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  in_item_t  item,
  input  logic      fire,
  output out_item_t result_next
);

  phase_t                  phase, phase_next;
  logic [TIMER_BITS-1:0]   phase_timer, phase_timer_next;
  logic                    phase_running, phase_running_next;
  logic [TIMER_BITS-1:0]   trigger_timer, trigger_timer_next;
  logic                    trigger_running, trigger_running_next;
  logic                    trigger_elapsed, trigger_elapsed_next;
  logic [SPEED_BITS-1:0]   motor_speed, motor_speed_next;
  logic                    forward_dir, forward_dir_next;
  logic                    motor_on, motor_on_next;
  logic [DRIVE_BITS-1:0]   drive_held, drive_held_next;

  logic [TIMER_BITS-1:0]   phase_dec, trigger_dec;
  logic                    seq_active, phase_done;
  logic                    stop_check, trigger_hit, start_backoff;
  logic [DRIVE_BITS-1:0]   drive_pos, drive_neg;

  assign phase_dec   = (phase_running && phase_timer != '0) ? phase_timer - 1'b1 : phase_timer;
  assign trigger_dec = (trigger_running && trigger_timer != '0) ?
                       trigger_timer - 1'b1 : trigger_timer;
  assign seq_active  = cfg.backoff_enable && phase != PH_INACTIVE;
  assign phase_done  = !phase_running || phase_dec == '0;

  // forward stop with backoff allowed checks the trigger timer
  assign stop_check    = !item.on_value && motor_on && forward_dir && cfg.backoff_enable;
  assign trigger_hit   = trigger_running && trigger_timer == '0;
  assign start_backoff = stop_check && (trigger_elapsed || trigger_hit);

  assign drive_pos = DRIVE_BITS'(motor_speed);
  assign drive_neg = DRIVE_BITS'(0) - drive_pos;

  always_comb begin
    phase_next           = phase;
    phase_timer_next     = phase_timer;
    phase_running_next   = phase_running;
    trigger_timer_next   = trigger_timer;
    trigger_running_next = trigger_running;
    trigger_elapsed_next = trigger_elapsed;
    motor_speed_next     = motor_speed;
    forward_dir_next     = forward_dir;
    motor_on_next        = motor_on;
    unique case (item.operation)
      OP_TICK: begin
        phase_timer_next   = phase_dec;
        trigger_timer_next = trigger_dec;
        if (seq_active) begin
          if (phase_running && phase_dec == '0) begin
            phase_running_next = 1'b0;
          end
          if (phase_done) begin
            unique case (phase)
              PH_HALT1: begin
                phase_next         = PH_REVERSE;
                phase_timer_next   = load_time(cfg.reverse_time);
                phase_running_next = 1'b1;
              end
              PH_REVERSE: begin
                phase_next         = PH_HALT2;
                phase_timer_next   = load_time(cfg.halt_time);
                phase_running_next = 1'b1;
              end
              PH_HALT2: begin
                phase_next         = PH_FORWARD;
                phase_timer_next   = load_time(cfg.forward_time);
                phase_running_next = 1'b1;
              end
              default: phase_next = PH_INACTIVE;
            endcase
          end
        end
      end
      OP_SET_SPEED: motor_speed_next = item.speed_value;
      OP_SET_DIR:   forward_dir_next = item.dir_value;
      OP_SET_ON: begin
        if (stop_check && trigger_hit) begin
          trigger_running_next = 1'b0;
          trigger_elapsed_next = 1'b1;
        end
        if (start_backoff) begin
          phase_next         = PH_HALT1;
          phase_timer_next   = load_time(cfg.halt_time);
          phase_running_next = 1'b1;
        end else if (item.on_value) begin
          if (!motor_on && forward_dir) begin
            trigger_timer_next   = load_time(cfg.trigger_time);
            trigger_running_next = 1'b1;
            trigger_elapsed_next = 1'b0;
          end
          phase_next = PH_INACTIVE;
        end
        motor_on_next = item.on_value;
      end
      default: ;
    endcase
  end

  always_comb begin
    drive_held_next = drive_held;
    unique case (item.operation)
      OP_TICK: begin
        if (seq_active) begin
          if (phase_done) begin
            unique case (phase)
              PH_HALT1:  drive_held_next = drive_neg;
              PH_HALT2:  drive_held_next = drive_pos;
              default:   drive_held_next = '0;
            endcase
          end
        end else if (!motor_on) begin
          drive_held_next = '0;
        end else if (forward_dir) begin
          drive_held_next = drive_pos;
        end else begin
          drive_held_next = drive_neg;
        end
      end
      OP_SET_ON: begin
        if (start_backoff) begin
          drive_held_next = '0;
        end
      end
      default: ;
    endcase
  end

  assign result_next.drive_speed = $signed(drive_held_next);
  assign result_next.phase       = phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_INACTIVE;
      phase_timer     <= '0;
      phase_running   <= 1'b0;
      trigger_timer   <= '0;
      trigger_running <= 1'b0;
      trigger_elapsed <= 1'b0;
      motor_speed     <= '0;
      forward_dir     <= 1'b1;
      motor_on        <= 1'b0;
      drive_held      <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      phase_timer     <= phase_timer_next;
      phase_running   <= phase_running_next;
      trigger_timer   <= trigger_timer_next;
      trigger_running <= trigger_running_next;
      trigger_elapsed <= trigger_elapsed_next;
      motor_speed     <= motor_speed_next;
      forward_dir     <= forward_dir_next;
      motor_on        <= motor_on_next;
      drive_held      <= drive_held_next;
    end
  end

endmodule
